/* src/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true at an edge requires cons true at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// expr must never be true
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

/* src/mdexp_pkg.sv */
package mdexp_pkg;

    localparam int FIELD_W       = 32;
    localparam int MAX_WIDTH     = 64;
    localparam int DEFAULT_WIDTH = 32;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

/* src/mdexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: acc = x * y mod m.
// One multiplier bit per cycle, MSB first: acc = 2*acc mod m, then + x mod m if the bit is set.
// Needs x < m; y may be any value (x = 1 gives y mod m).
module mdexp_mulmod #(
    parameter int WIDTH = mdexp_pkg::DEFAULT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [WIDTH-1:0]       i_x,
    input  logic [WIDTH-1:0]       i_y,
    input  logic [WIDTH-1:0]       i_m,
    output logic [WIDTH-1:0]       o_acc,
    output mdexp_pkg::t_mm_status  o_status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   w_dbl;
    logic [WIDTH:0]   w_dbl_red;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_m_ext;
    logic [WIDTH-1:0] w_addend;
    logic [WIDTH-1:0] n_acc;

    always_comb begin
        w_m_ext   = {1'b0, r_m};
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= w_m_ext) ? (w_dbl - w_m_ext) : w_dbl;
        w_addend  = r_y[WIDTH-1] ? r_x : '0;
        w_sum     = w_dbl_red + {1'b0, w_addend};
        if (w_sum >= w_m_ext) begin
            n_acc = WIDTH'(w_sum - w_m_ext);
        end else begin
            n_acc = w_sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_acc           = r_acc;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

/* src/modular_exponentiation.sv */
// Modular exponentiation, square and multiply over one shared bit-serial modmul unit.
// Each modmul is a bit-serial pass; after accept the base is reduced mod m, then each of the WIDTH
// exponent bits, MSB first, takes a square and, when set, a multiply; S_FINISH waits on output stalls;
// zero modulus or zero exponent skips the multiplier. Input ready returns as output valid rises.
// One transaction at a time: input ready only while the sequencer is idle.
// Reset (synchronous, active low) clears the sequencer, the multiplier and output valid.
module modular_exponentiation #(
    parameter int WIDTH = mdexp_pkg::DEFAULT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,  // base_value, exponent_value, modulus_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // power_result
    output logic [0:0]  o_m_axis_tuser   // zero_modulus_error
);

    `include "assert_macros.svh"

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int FW    = mdexp_pkg::FIELD_W;
    localparam int MW    = mdexp_pkg::MAX_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_exp;
    logic [CNT_W-1:0] r_bitcnt;
    logic             r_err;
    logic             r_o_valid;
    logic [FW-1:0]    r_o_data;
    logic             r_o_err;

    logic [WIDTH-1:0] w_base_in;
    logic [WIDTH-1:0] w_exp_in;
    logic [WIDTH-1:0] w_mod_in;
    logic [WIDTH-1:0] w_one_mod;
    logic             w_accept;
    logic             w_trivial;
    logic             w_mm_wait;

    logic             w_mm_start;
    logic [WIDTH-1:0] w_mm_x;
    logic [WIDTH-1:0] w_mm_y;
    logic [WIDTH-1:0] w_mm_m;
    logic [WIDTH-1:0] w_mm_acc;
    mdexp_pkg::t_mm_status w_mm_sts;

    logic [MW-1:0]    w_res_ext;

    // operands masked to WIDTH bits
    assign w_base_in = WIDTH'(MW'(i_s_axis_tdata[FW-1:0]));
    assign w_exp_in  = WIDTH'(MW'(i_s_axis_tdata[2*FW-1:FW]));
    assign w_mod_in  = WIDTH'(MW'(i_s_axis_tdata[3*FW-1:2*FW]));
    assign w_one_mod = (w_mod_in == WIDTH'(1)) ? '0 : WIDTH'(1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_trivial       = (w_mod_in == '0) || (w_exp_in == '0);
    assign w_mm_wait       = (r_state == S_RED_WAIT) || (r_state == S_SQ_WAIT) ||
                             (r_state == S_MUL_WAIT);

    always_comb begin
        w_mm_start = 1'b0;
        w_mm_x     = r_acc;
        w_mm_y     = r_acc;
        w_mm_m     = r_mod;
        unique case (r_state)
            S_IDLE: begin
                // base mod m, computed as 1 * base
                w_mm_start = w_accept && !w_trivial;
                w_mm_x     = w_one_mod;
                w_mm_y     = w_base_in;
                w_mm_m     = w_mod_in;
            end
            S_SQ_GO: begin
                w_mm_start = 1'b1;
            end
            S_MUL_GO: begin
                w_mm_start = 1'b1;
                w_mm_x     = r_b;
            end
            default: begin
                w_mm_start = 1'b0;
            end
        endcase
    end

    mdexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mm_start),
        .i_x      (w_mm_x),
        .i_y      (w_mm_y),
        .i_m      (w_mm_m),
        .o_acc    (w_mm_acc),
        .o_status (w_mm_sts)
    );

    assign w_res_ext = MW'(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // S_FINISH reloads the output register itself
            if (r_o_valid && i_m_axis_tready && (r_state != S_FINISH)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mod    <= w_mod_in;
                        r_exp    <= w_exp_in;
                        r_bitcnt <= CNT_W'(WIDTH - 1);
                        r_err    <= (w_mod_in == '0);
                        if (w_mod_in == '0) begin
                            r_acc   <= '0;
                            r_state <= S_FINISH;
                        end else if (w_exp_in == '0) begin
                            r_acc   <= WIDTH'(1);
                            r_state <= S_FINISH;
                        end else begin
                            r_acc   <= w_one_mod;
                            r_state <= S_RED_WAIT;
                        end
                    end
                end
                S_RED_WAIT: begin
                    if (w_mm_sts.done) begin
                        r_b     <= w_mm_acc;
                        r_state <= S_SQ_GO;
                    end
                end
                S_SQ_GO: begin
                    r_state <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (w_mm_sts.done) begin
                        r_acc <= w_mm_acc;
                        if (r_exp[WIDTH-1]) begin
                            r_state <= S_MUL_GO;
                        end else if (r_bitcnt == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_bitcnt <= r_bitcnt - 1'b1;
                            r_exp    <= {r_exp[WIDTH-2:0], 1'b0};
                            r_state  <= S_SQ_GO;
                        end
                    end
                end
                S_MUL_GO: begin
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (w_mm_sts.done) begin
                        r_acc <= w_mm_acc;
                        if (r_bitcnt == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_bitcnt <= r_bitcnt - 1'b1;
                            r_exp    <= {r_exp[WIDTH-2:0], 1'b0};
                            r_state  <= S_SQ_GO;
                        end
                    end
                end
                S_FINISH: begin
                    // wait for the output register to free up
                    if (!r_o_valid || i_m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= w_res_ext[FW-1:0];
                        r_o_err   <= r_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_err;

    `ASSERT_NEVER(a_no_restart, i_clk, i_rst_n, w_mm_start && w_mm_sts.busy)
    `ASSERT_IMPLIES(a_done_in_wait, i_clk, i_rst_n, w_mm_sts.done, w_mm_wait)
    `ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0)

endmodule
